FILE: rtl/kct_pkg.sv
// Shared types and constants for the keyed count table.
package kct_pkg;

	localparam int KEY_IN_W = 16;
	localparam int COUNT_W  = 8;
	localparam int SLOT_W   = 5;

	typedef enum logic {
		OP_ADD = 1'b0,
		OP_SUB = 1'b1
	} kct_op_t;

	// Control part of the search token that walks down the row of cells.
	typedef struct packed {
		logic    valid;
		kct_op_t op;
		logic    hit;
		logic    emp;
	} kct_tok_t;

endpackage

FILE: rtl/kct_cell.sv
// One table slot: holds a key and a count and updates the passing search token.
module kct_cell #(
	parameter int KEY_BITS = 16,
	parameter int IDX_W    = 5,
	parameter int IDX      = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kct_pkg::kct_tok_t      tok_in,
	input  logic [KEY_BITS-1:0]    key_in,
	input  logic [kct_pkg::COUNT_W-1:0] amt_in,
	input  logic [IDX_W-1:0]       hit_idx_in,
	input  logic [kct_pkg::COUNT_W-1:0] hit_cnt_in,
	input  logic [IDX_W-1:0]       emp_idx_in,
	output kct_pkg::kct_tok_t      tok_out,
	output logic [KEY_BITS-1:0]    key_out,
	output logic [kct_pkg::COUNT_W-1:0] amt_out,
	output logic [IDX_W-1:0]       hit_idx_out,
	output logic [kct_pkg::COUNT_W-1:0] hit_cnt_out,
	output logic [IDX_W-1:0]       emp_idx_out,
	input  logic                   wr_en,
	input  logic [IDX_W-1:0]       wr_idx,
	input  logic [KEY_BITS-1:0]    wr_key,
	input  logic [kct_pkg::COUNT_W-1:0] wr_cnt
);
	import kct_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [KEY_BITS-1:0] key_q;
	logic [COUNT_W-1:0]  count_q;
	kct_tok_t            tok_q;
	logic [KEY_BITS-1:0] tkey_q;
	logic [COUNT_W-1:0]  amt_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [COUNT_W-1:0]  hit_cnt_q;
	logic [IDX_W-1:0]    emp_idx_q;
	logic                is_match;
	logic                is_empty;
	logic                take_hit;
	logic                take_emp;

	assign is_match = (key_q == key_in);
	assign is_empty = (key_q == '0) && (count_q == '0);
	// Only the first matching or empty cell along the row claims the token.
	assign take_hit = !tok_in.hit && is_match;
	assign take_emp = !tok_in.emp && is_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			count_q <= '0;
		end else if (wr_en && (wr_idx == MY_IDX)) begin
			key_q   <= wr_key;
			count_q <= wr_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.op    <= tok_in.op;
			tok_q.hit   <= tok_in.hit || is_match;
			tok_q.emp   <= tok_in.emp || is_empty;
		end
	end

	always_ff @(posedge clk) begin
		tkey_q    <= key_in;
		amt_q     <= amt_in;
		hit_idx_q <= take_hit ? MY_IDX : hit_idx_in;
		hit_cnt_q <= take_hit ? count_q : hit_cnt_in;
		emp_idx_q <= take_emp ? MY_IDX : emp_idx_in;
	end

	assign tok_out     = tok_q;
	assign key_out     = tkey_q;
	assign amt_out     = amt_q;
	assign hit_idx_out = hit_idx_q;
	assign hit_cnt_out = hit_cnt_q;
	assign emp_idx_out = emp_idx_q;

endmodule

FILE: rtl/keyed_count_table_core.sv
// Keyed count table: a row of slot cells searched by a token, with a final update stage.
//
// A request (start high while busy is low) enters a row of SLOTS cells and moves one
// cell per clock, each cell noting whether it holds the lowest matching key or the
// lowest empty slot. When the token leaves the last cell the update is written back to
// the chosen slot and the registered result shows on ok, slot and count with done high
// for one cycle. busy rises after acceptance and falls as the token leaves the last cell,
// so a new request can be taken in the cycle the result is shown; no new request is
// taken while one walks the row. Results cannot be held off by the receiver. The table
// is cleared at reset.
module keyed_count_table_core #(
	parameter int SLOTS    = 32,
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [kct_pkg::KEY_IN_W-1:0] key,
	input  logic [kct_pkg::COUNT_W-1:0]  amount,
	output logic                         done,
	output logic                         ok,
	output logic [kct_pkg::SLOT_W-1:0]   slot,
	output logic [kct_pkg::COUNT_W-1:0]  count
);
	import kct_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	kct_tok_t            tok     [SLOTS+1];
	logic [KEY_BITS-1:0] tkey    [SLOTS+1];
	logic [COUNT_W-1:0]  tamt    [SLOTS+1];
	logic [IDX_W-1:0]    hit_idx [SLOTS+1];
	logic [COUNT_W-1:0]  hit_cnt [SLOTS+1];
	logic [IDX_W-1:0]    emp_idx [SLOTS+1];

	logic                busy_q;
	logic                accept;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_idx;
	logic [KEY_BITS-1:0] wr_key;
	logic [COUNT_W-1:0]  wr_cnt;
	kct_tok_t            fin;

	logic                done_q;
	logic                ok_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [COUNT_W-1:0]  count_q;

	assign accept = start && !busy_q;

	assign tok[0].valid = accept;
	assign tok[0].op    = kct_op_t'(op);
	assign tok[0].hit   = 1'b0;
	assign tok[0].emp   = 1'b0;
	assign tkey[0]      = KEY_BITS'(key);
	assign tamt[0]      = amount;
	assign hit_idx[0]   = '0;
	assign hit_cnt[0]   = '0;
	assign emp_idx[0]   = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		kct_cell #(
			.KEY_BITS(KEY_BITS),
			.IDX_W   (IDX_W),
			.IDX     (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tok_in     (tok[i]),
			.key_in     (tkey[i]),
			.amt_in     (tamt[i]),
			.hit_idx_in (hit_idx[i]),
			.hit_cnt_in (hit_cnt[i]),
			.emp_idx_in (emp_idx[i]),
			.tok_out    (tok[i+1]),
			.key_out    (tkey[i+1]),
			.amt_out    (tamt[i+1]),
			.hit_idx_out(hit_idx[i+1]),
			.hit_cnt_out(hit_cnt[i+1]),
			.emp_idx_out(emp_idx[i+1]),
			.wr_en      (wr_en),
			.wr_idx     (wr_idx),
			.wr_key     (wr_key),
			.wr_cnt     (wr_cnt)
		);
	end

	assign fin = tok[SLOTS];

	always_comb begin
		wr_en  = 1'b0;
		wr_idx = hit_idx[SLOTS];
		wr_key = tkey[SLOTS];
		wr_cnt = hit_cnt[SLOTS] + tamt[SLOTS];
		if (fin.valid) begin
			if (fin.op == OP_ADD) begin
				if (fin.hit) begin
					wr_en = 1'b1;
				end else if (fin.emp) begin
					wr_en  = 1'b1;
					wr_idx = emp_idx[SLOTS];
					wr_cnt = tamt[SLOTS];
				end
			end else if (fin.hit && (hit_cnt[SLOTS] >= tamt[SLOTS])) begin
				wr_en  = 1'b1;
				wr_cnt = hit_cnt[SLOTS] - tamt[SLOTS];
				// An exact take-out frees the slot.
				if (hit_cnt[SLOTS] == tamt[SLOTS]) begin
					wr_key = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin.valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ok_q    <= wr_en;
		slot_q  <= wr_en ? SLOT_W'(wr_idx) : '0;
		count_q <= wr_en ? wr_cnt : '0;
	end

	assign busy  = busy_q;
	assign done  = done_q;
	assign ok    = ok_q;
	assign slot  = slot_q;
	assign count = count_q;

endmodule

FILE: sim/keyed_count_table_core_test.sv
// Self-checking testbench for the keyed count table core: directed table, then random traffic.
module keyed_count_table_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kct_pkg::*;

	localparam int SLOTS       = 32;
	localparam int KEY_BITS    = 16;
	localparam int LATENCY     = SLOTS + 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SEGMENTS    = 5;
	localparam int SEG_ITEMS   = 150;
	localparam int POOL        = 48;
	localparam int MAX_GAP     = 40;

	typedef struct packed {
		logic               ok;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} tally_t;

	typedef struct packed {
		kct_op_t             op;
		logic [KEY_IN_W-1:0] key;
		logic [COUNT_W-1:0]  amount;
		logic                typed;
		tally_t              want;
	} stim_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                op;
	logic [KEY_IN_W-1:0] key;
	logic [COUNT_W-1:0]  amount;
	logic                done;
	logic                ok;
	logic [SLOT_W-1:0]   slot;
	logic [COUNT_W-1:0]  count;

	keyed_count_table_core #(
		.SLOTS(SLOTS),
		.KEY_BITS(KEY_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.key(key),
		.amount(amount),
		.done(done),
		.ok(ok),
		.slot(slot),
		.count(count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the table, updated when a request is taken.
	logic [KEY_IN_W-1:0] shadow_key [SLOTS];
	logic [COUNT_W-1:0]  shadow_cnt [SLOTS];
	tally_t              pending_tallies[$];
	int                  mismatches = 0;
	int                  cycles = 0;
	int                  n_requests = 0;
	int                  n_done = 0;
	int                  n_full = 0;
	int                  n_refused = 0;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			shadow_key[i] = '0;
			shadow_cnt[i] = '0;
		end
	end

	function automatic int lowest_with_key(logic [KEY_IN_W-1:0] k);
		for (int i = 0; i < SLOTS; i++)
			if (shadow_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic int lowest_free();
		for (int i = 0; i < SLOTS; i++)
			if (shadow_key[i] == '0 && shadow_cnt[i] == '0)
				return i;
		return -1;
	endfunction

	function automatic tally_t apply_request(kct_op_t op_i, logic [KEY_IN_W-1:0] k,
			logic [COUNT_W-1:0] amt);
		int idx;
		tally_t r;
		r = '0;
		idx = lowest_with_key(k);
		if (op_i == OP_ADD) begin
			if (idx < 0) begin
				idx = lowest_free();
				if (idx >= 0) begin
					shadow_key[idx] = k;
					shadow_cnt[idx] = '0;
				end
			end
			if (idx >= 0) begin
				shadow_cnt[idx] = shadow_cnt[idx] + amt;
				r.ok = 1'b1;
			end else
				n_full++;
		end else if (idx >= 0 && shadow_cnt[idx] >= amt) begin
			// Taking the whole count frees the slot, key included.
			shadow_cnt[idx] = shadow_cnt[idx] - amt;
			if (shadow_cnt[idx] == '0)
				shadow_key[idx] = '0;
			r.ok = 1'b1;
		end else
			n_refused++;
		if (r.ok) begin
			r.slot  = idx[SLOT_W-1:0];
			r.count = shadow_cnt[idx];
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("tb: mismatch on %s: got %0d, want %0d (cycle %0d)", what, got, want,
				cycles);
		mismatches++;
	endtask

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_request(input kct_op_t op_i, input logic [KEY_IN_W-1:0] k,
			input logic [COUNT_W-1:0] amt, input logic typed, input tally_t want);
		tally_t predicted;
		start  <= 1'b1;
		op     <= op_i;
		key    <= k;
		amount <= amt;
		do
			@(posedge clk);
		while (busy);
		predicted = apply_request(op_i, k, amt);
		pending_tallies.push_back(typed ? want : predicted);
		n_requests++;
		@(negedge clk);
	endtask

	task automatic maybe_idle(input bit quiet);
		if (!quiet && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
		end
	endtask

	// Always moves on by at least one falling edge, so start is not driven twice at once.
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_tallies.size() != 0);
	endtask

	always @(posedge clk) begin : result_check
		tally_t w;
		if (arst_n && done) begin
			n_done++;
			if (pending_tallies.size() == 0)
				report_mismatch("result with no request pending", 1, 0);
			else begin
				w = pending_tallies.pop_front();
				if (ok !== w.ok)
					report_mismatch("ok", int'(ok), int'(w.ok));
				if (slot !== w.slot)
					report_mismatch("slot", int'(slot), int'(w.slot));
				if (count !== w.count)
					report_mismatch("count", int'(count), int'(w.count));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Rows with typed results follow from reset state at a glance; the rest use the shadow.
	stim_row_t directed [18] = '{
		'{OP_SUB, 16'h0005,   8'd1, 1'b1, '{1'b0, 5'd0, 8'd0}},
		'{OP_ADD, 16'h0000,   8'd0, 1'b1, '{1'b1, 5'd0, 8'd0}},
		'{OP_ADD, 16'hFFFF, 8'd255, 1'b1, '{1'b1, 5'd0, 8'd255}},
		'{OP_ADD, 16'hFFFF,   8'd1, 1'b1, '{1'b1, 5'd0, 8'd0}},
		'{OP_SUB, 16'hFFFF,   8'd0, 1'b1, '{1'b1, 5'd0, 8'd0}},
		'{OP_SUB, 16'hFFFF,   8'd0, 1'b1, '{1'b0, 5'd0, 8'd0}},
		'{OP_ADD, 16'h0000,   8'd7, 1'b1, '{1'b1, 5'd0, 8'd7}},
		'{OP_ADD, 16'h1234,  8'd10, 1'b1, '{1'b1, 5'd1, 8'd10}},
		'{OP_SUB, 16'h0000,   8'd8, 1'b1, '{1'b0, 5'd0, 8'd0}},
		'{OP_SUB, 16'h0000,   8'd3, 1'b0, '0},
		'{OP_SUB, 16'h0000,   8'd4, 1'b0, '0},
		'{OP_SUB, 16'h1234,  8'd11, 1'b1, '{1'b0, 5'd0, 8'd0}},
		'{OP_ADD, 16'h1234, 8'd200, 1'b0, '0},
		'{OP_ADD, 16'hA5C3, 8'd128, 1'b0, '0},
		'{OP_SUB, 16'h1234, 8'd210, 1'b0, '0},
		'{OP_ADD, 16'h5A3C, 8'd255, 1'b0, '0},
		'{OP_SUB, 16'h5A3C, 8'd255, 1'b0, '0},
		'{OP_SUB, 16'hA5C3,   8'd0, 1'b0, '0}
	};

	// Share of adds per random segment: fill to full first, then drain and refill.
	int add_share [SEGMENTS] = '{100, 40, 70, 25, 60};

	initial begin : stimulus
		logic [KEY_IN_W-1:0] pool [POOL];
		logic [KEY_IN_W-1:0] k;
		logic [COUNT_W-1:0]  amt;
		kct_op_t             op_r;
		int                  idx;
		int                  pick;
		arst_n = 1'b0;
		start  = 1'b0;
		op     = OP_ADD;
		key    = '0;
		amount = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_request(directed[i].op, directed[i].key, directed[i].amount,
				directed[i].typed, directed[i].want);
			maybe_idle(1'b0);
		end
		drain();

		for (int s = 0; s < SEGMENTS; s++) begin
			foreach (pool[j])
				pool[j] = KEY_IN_W'($urandom_range(1, 16'hFFFF));
			for (int n = 0; n < SEG_ITEMS; n++) begin
				k = ($urandom_range(0, 19) == 0) ? '0 : pool[$urandom_range(0, POOL - 1)];
				op_r = ($urandom_range(0, 99) < add_share[s]) ? OP_ADD : OP_SUB;
				amt = COUNT_W'($urandom_range(0, 255));
				idx = lowest_with_key(k);
				pick = $urandom_range(0, 9);
				// Most subtracts are sized against what the slot holds.
				if (op_r == OP_SUB && idx >= 0) begin
					if (pick < 5)
						amt = shadow_cnt[idx];
					else if (pick < 8)
						amt = COUNT_W'($urandom_range(0, shadow_cnt[idx]));
				end
				send_request(op_r, k, amt, 1'b0, '0);
				maybe_idle(s == 2);
			end
			if (s % 2 == 1)
				drain();
		end

		drain();
		repeat (LATENCY + 8) @(negedge clk);
		$display("Covered %0d requests with %0d results checked over %0d cycles.",
			n_requests, n_done, cycles);
		$display("Refused: %0d adds on a full table, %0d subtracts absent or short.",
			n_full, n_refused);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
rtl/kct_pkg.sv
rtl/kct_cell.sv
rtl/keyed_count_table_core.sv
sim/keyed_count_table_core_test.sv
